// ===== rtl/palette_rle_image_decoder_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the palette run-length image decoder
// Checks sample on clk and are ignored while rst is high.
// ----------------------------------------------------------------------------
`ifndef PALETTE_RLE_IMAGE_DECODER_TOP_MACROS_SVH
`define PALETTE_RLE_IMAGE_DECODER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PRID_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PRID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/prid_pkg.sv =====
// ----------------------------------------------------------------------------
// prid_pkg
// Shared widths and constants of the palette run-length image decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package prid_pkg;

  localparam int PALETTE_ENTRIES = 16;
  localparam int PAL_IDX_W       = $clog2(PALETTE_ENTRIES);
  localparam int BYTE_W          = 8;
  localparam int RGB_W           = 3 * BYTE_W;
  localparam int DIM_W           = 16;
  localparam int OFFSET_W        = 32;
  localparam int LEN_W           = 15;
  localparam int SHORT_LEN_W     = 7;
  localparam int HEADER_BYTES    = 4 + 3 * PALETTE_ENTRIES;
  localparam int HDR_CNT_W       = $clog2(HEADER_BYTES + 1);

endpackage

`default_nettype wire

// ===== rtl/prid_byte_if.sv =====
// ----------------------------------------------------------------------------
// prid_byte_if
// Byte request channel: one encoded file byte plus the image start mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface prid_byte_if;
  import prid_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              image_start;

  modport source (output valid, output data_byte, output image_start, input ready);
  modport sink   (input valid, input data_byte, input image_start, output ready);

endinterface

`default_nettype wire

// ===== rtl/prid_run_if.sv =====
// ----------------------------------------------------------------------------
// prid_run_if
// Run request channel: one decoded run or end marker of an image.
// ----------------------------------------------------------------------------
`default_nettype none

interface prid_run_if;
  import prid_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [PAL_IDX_W-1:0] color_index;
  logic [BYTE_W-1:0]    red;
  logic [BYTE_W-1:0]    green;
  logic [BYTE_W-1:0]    blue;
  logic [OFFSET_W-1:0]  start_offset;
  logic [LEN_W-1:0]     run_length;
  logic [DIM_W-1:0]     image_width;
  logic [DIM_W-1:0]     image_height;
  logic                 image_done;

  modport source (
    output valid, input ready,
    output color_index, output red, output green, output blue,
    output start_offset, output run_length,
    output image_width, output image_height, output image_done
  );
  modport sink (
    input valid, output ready,
    input color_index, input red, input green, input blue,
    input start_offset, input run_length,
    input image_width, input image_height, input image_done
  );

endinterface

`default_nettype wire

// ===== rtl/prid_ram.sv =====
// ----------------------------------------------------------------------------
// prid_ram
// Generic single-write, single-read RAM with a registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module prid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold the last read word when no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/palette_rle_image_decoder_top.sv =====
// ----------------------------------------------------------------------------
// palette_rle_image_decoder_top
// Parses a palette run-length image file byte by byte and reports each run.
// ----------------------------------------------------------------------------
//
//   channel  dir  carries
//   -------  ---  -----------------------------------------------------------
//   bytes    in   data_byte, image_start: one file byte per request
//   runs     out  color_index, red/green/blue, start_offset, run_length,
//                 image_width, image_height, image_done: at most one per byte
//
// One byte is taken every cycle while bytes.ready is high. A byte that closes a run loads the output
// register and reads the palette RAM in the same edge, so the run's RGB sits
// in the RAM read register alongside it, and the result appears in the next cycle.
// rst clears the parser and the output valid; the palette RAM is not cleared,
// since every image rewrites all entries before any run can read them.
// bytes.ready drops only while a result waits and runs.ready is low.
//
`default_nettype none

module palette_rle_image_decoder_top (
  input  wire logic clk,
  input  wire logic rst,
  prid_byte_if.sink bytes,
  prid_run_if.source runs
);

  import prid_pkg::*;

  `include "palette_rle_image_decoder_top_macros.svh"

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_TOK1,
    PH_TOK2,
    PH_TOK3,
    PH_DONE
  } phase_t;

  // Parser state
  phase_t                  phase;
  logic [HDR_CNT_W-1:0]    header_count;
  logic [PAL_IDX_W-1:0]    pal_entry;
  logic [1:0]              pal_comp;
  logic [BYTE_W-1:0]       pal_green;
  logic [BYTE_W-1:0]       pal_red;
  logic [DIM_W-1:0]        width_reg;
  logic [DIM_W-1:0]        height_reg;
  logic [OFFSET_W-1:0]     total_pixels;
  logic [OFFSET_W-1:0]     pixel_offset;
  logic [PAL_IDX_W-1:0]    token_first;
  logic [SHORT_LEN_W-1:0]  token_second;

  // Output register (RGB comes from the RAM read register)
  logic                    out_valid;
  logic                    out_bare;
  logic [PAL_IDX_W-1:0]    out_color;
  logic [OFFSET_W-1:0]     out_start;
  logic [LEN_W-1:0]        out_len;
  logic [DIM_W-1:0]        out_width;
  logic [DIM_W-1:0]        out_height;
  logic                    out_done;
  logic [RGB_W-1:0]        pal_rdata;

  // Next values
  phase_t                  phase_next;
  logic [HDR_CNT_W-1:0]    header_count_next;
  logic [PAL_IDX_W-1:0]    pal_entry_next;
  logic [1:0]              pal_comp_next;
  logic [BYTE_W-1:0]       pal_green_next;
  logic [BYTE_W-1:0]       pal_red_next;
  logic [DIM_W-1:0]        width_reg_next;
  logic [DIM_W-1:0]        height_reg_next;
  logic [OFFSET_W-1:0]     total_pixels_next;
  logic [OFFSET_W-1:0]     pixel_offset_next;
  logic [PAL_IDX_W-1:0]    token_first_next;
  logic [SHORT_LEN_W-1:0]  token_second_next;

  // Per-byte decode
  phase_t                  eff_phase;
  logic [HDR_CNT_W-1:0]    eff_hcnt;
  logic [PAL_IDX_W-1:0]    eff_entry;
  logic [1:0]              eff_comp;
  logic [BYTE_W-1:0]       b;
  logic                    accept;
  logic                    run_emit;
  logic [PAL_IDX_W-1:0]    run_color;
  logic [LEN_W-1:0]        run_len;
  logic                    run_valid;
  logic [OFFSET_W:0]       run_end;
  logic [OFFSET_W-1:0]     pixels_left;
  logic                    run_fills;
  logic                    bare;
  logic [OFFSET_W-1:0]     bare_start;
  logic                    res_valid;
  logic [LEN_W-1:0]        res_len;
  logic [OFFSET_W-1:0]     res_start;
  logic                    pal_we;

  assign b            = bytes.data_byte;
  assign bytes.ready  = !out_valid || runs.ready;
  assign accept       = bytes.valid && bytes.ready;

  always_comb begin
    // a start mark restarts the parser on this very byte
    eff_phase = bytes.image_start ? PH_HEADER : phase;
    eff_hcnt  = bytes.image_start ? '0 : header_count;
    eff_entry = bytes.image_start ? '0 : pal_entry;
    eff_comp  = bytes.image_start ? '0 : pal_comp;

    phase_next        = eff_phase;
    header_count_next = eff_hcnt;
    pal_entry_next    = eff_entry;
    pal_comp_next     = eff_comp;
    pal_green_next    = pal_green;
    pal_red_next      = pal_red;
    width_reg_next    = width_reg;
    height_reg_next   = height_reg;
    total_pixels_next = total_pixels;
    pixel_offset_next = bytes.image_start ? '0 : pixel_offset;
    token_first_next  = bytes.image_start ? '0 : token_first;
    token_second_next = bytes.image_start ? '0 : token_second;

    run_emit   = 1'b0;
    run_color  = '0;
    run_len    = '0;
    bare       = 1'b0;
    bare_start = pixel_offset;
    pal_we     = 1'b0;

    unique case (eff_phase)
      PH_HEADER: begin
        header_count_next = eff_hcnt + 1'b1;
        if (eff_hcnt == HDR_CNT_W'(0)) begin
          width_reg_next = {{(DIM_W-BYTE_W){1'b0}}, b};
        end else if (eff_hcnt == HDR_CNT_W'(1)) begin
          width_reg_next = {b, width_reg[BYTE_W-1:0]};
        end else if (eff_hcnt == HDR_CNT_W'(2)) begin
          height_reg_next = {{(DIM_W-BYTE_W){1'b0}}, b};
        end else if (eff_hcnt == HDR_CNT_W'(3)) begin
          height_reg_next   = {b, height_reg[BYTE_W-1:0]};
          total_pixels_next = OFFSET_W'(width_reg) * OFFSET_W'(height_reg_next);
        end else begin
          // palette bytes arrive green, red, blue; write the entry on blue
          unique case (eff_comp)
            2'd0: begin
              pal_green_next = b;
              pal_comp_next  = 2'd1;
            end
            2'd1: begin
              pal_red_next  = b;
              pal_comp_next = 2'd2;
            end
            default: begin
              pal_we         = 1'b1;
              pal_comp_next  = 2'd0;
              pal_entry_next = eff_entry + 1'b1;
            end
          endcase
          if (eff_hcnt == HDR_CNT_W'(HEADER_BYTES - 1)) begin
            pixel_offset_next = '0;
            if (total_pixels == '0) begin
              bare       = 1'b1;
              bare_start = '0;
              phase_next = PH_DONE;
            end else begin
              phase_next = PH_TOK1;
            end
          end
        end
      end
      PH_TOK1: begin
        if (b >= BYTE_W'(16)) begin
          run_emit  = 1'b1;
          run_color = b[PAL_IDX_W-1:0];
          run_len   = LEN_W'(b[BYTE_W-1:4]);
        end else begin
          token_first_next = b[PAL_IDX_W-1:0];
          phase_next       = PH_TOK2;
        end
      end
      PH_TOK2: begin
        if (token_first == '0 && b == '0) begin
          // end marker
          bare       = 1'b1;
          phase_next = PH_DONE;
        end else if (b[BYTE_W-1]) begin
          token_second_next = b[SHORT_LEN_W-1:0];
          phase_next        = PH_TOK3;
        end else begin
          run_emit  = 1'b1;
          run_color = token_first;
          run_len   = LEN_W'(b[SHORT_LEN_W-1:0]);
        end
      end
      PH_TOK3: begin
        run_emit  = 1'b1;
        run_color = token_first;
        run_len   = {b, token_second};
      end
      default: begin
        // idle or finished: drop the byte
      end
    endcase

    // Clip the run against the pixels left in the image
    run_end     = {1'b0, pixel_offset} + (OFFSET_W+1)'(run_len);
    pixels_left = total_pixels - pixel_offset;
    run_fills   = run_end >= {1'b0, total_pixels};
    run_valid   = run_emit && (run_len != '0);
    if (run_emit) begin
      phase_next = PH_TOK1;
    end
    if (run_valid) begin
      pixel_offset_next = run_fills ? total_pixels : run_end[OFFSET_W-1:0];
      if (run_fills) begin
        phase_next = PH_DONE;
      end
    end

    res_valid = run_valid || bare;
    res_len   = (run_valid && run_fills) ? pixels_left[LEN_W-1:0] : run_len;
    res_start = bare ? bare_start : pixel_offset;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      header_count <= '0;
      pal_entry    <= '0;
      pal_comp     <= '0;
      width_reg    <= '0;
      height_reg   <= '0;
      total_pixels <= '0;
      pixel_offset <= '0;
      token_first  <= '0;
      token_second <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        phase        <= phase_next;
        header_count <= header_count_next;
        pal_entry    <= pal_entry_next;
        pal_comp     <= pal_comp_next;
        pal_green    <= pal_green_next;
        pal_red      <= pal_red_next;
        width_reg    <= width_reg_next;
        height_reg   <= height_reg_next;
        total_pixels <= total_pixels_next;
        pixel_offset <= pixel_offset_next;
        token_first  <= token_first_next;
        token_second <= token_second_next;
        out_valid    <= res_valid;
        if (res_valid) begin
          out_bare   <= bare;
          out_color  <= bare ? '0 : run_color;
          out_start  <= res_start;
          out_len    <= bare ? '0 : res_len;
          out_width  <= width_reg_next;
          out_height <= height_reg_next;
          out_done   <= bare || run_fills;
        end
      end else if (runs.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Palette store: written on each blue byte, read when a run is reported
  prid_ram #(
    .WIDTH (RGB_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (accept && pal_we),
    .waddr (eff_entry),
    .wdata ({pal_red, pal_green, b}),
    .re    (accept && run_valid),
    .raddr (run_color),
    .rdata (pal_rdata)
  );

  assign runs.valid        = out_valid;
  assign runs.color_index  = out_color;
  assign runs.red          = out_bare ? '0 : pal_rdata[RGB_W-1 -: BYTE_W];
  assign runs.green        = out_bare ? '0 : pal_rdata[2*BYTE_W-1 -: BYTE_W];
  assign runs.blue         = out_bare ? '0 : pal_rdata[BYTE_W-1:0];
  assign runs.start_offset = out_start;
  assign runs.run_length   = out_len;
  assign runs.image_width  = out_width;
  assign runs.image_height = out_height;
  assign runs.image_done   = out_done;

  // Decoding runs never sit at or past the end of the image
  `PRID_ASSERT_NOW(a_offset_inside, (phase == PH_TOK1 || phase == PH_TOK2 || phase == PH_TOK3), (pixel_offset < total_pixels), "pixel offset reached image size while decoding")

  // A finished image drops bytes without results until restarted
  `PRID_ASSERT_NEXT(a_done_silent, (accept && phase == PH_DONE && !bytes.image_start), (!runs.valid), "result after image completion")

  // A pending run that does not finish the image leaves the parser at a token start
  `PRID_ASSERT_NOW(a_open_run_phase, (runs.valid && !runs.image_done), (phase == PH_TOK1), "open run pending outside token start")

endmodule

`default_nettype wire
